>>> rtl/core/dhcprp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcprp_pkg
// Shared types and constants for the DHCP reply parser.
// ----------------------------------------------------------------------------
package dhcprp_pkg;

    localparam logic [15:0] HDR_LEN      = 16'd240;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;
    localparam logic [15:0] XID_LAST     = 16'd7;
    localparam logic [15:0] YIADDR_LAST  = 16'd19;
    localparam logic [15:0] SIADDR_LAST  = 16'd23;
    localparam logic [15:0] COOKIE_LAST  = 16'd239;
    localparam logic [31:0] DHCP_COOKIE  = 32'h6382_5363;
    localparam logic [31:0] MASK_RESET   = 32'hFFFF_FF00;

    localparam logic [7:0] OPT_PAD    = 8'd0;
    localparam logic [7:0] OPT_END    = 8'hFF;
    localparam logic [7:0] OPT_TYPE   = 8'd53;
    localparam logic [7:0] OPT_SERVER = 8'd54;
    localparam logic [7:0] OPT_MASK   = 8'd1;
    localparam logic [7:0] OPT_ROUTER = 8'd3;
    localparam logic [7:0] OPT_DNS    = 8'd6;

    localparam logic [7:0] MT_OFFER = 8'd2;
    localparam logic [7:0] MT_ACK   = 8'd5;
    localparam logic [7:0] MT_NAK   = 8'd6;

    // slot bits: 0 type, 1 server id, 2 mask, 3 router, 4 dns
    localparam int NUM_SLOTS = 5;

    typedef enum logic [2:0] {
        ST_SHORT   = 3'd0,
        ST_XID     = 3'd1,
        ST_COOKIE  = 3'd2,
        ST_NO_TYPE = 3'd3,
        ST_OFFER   = 3'd4,
        ST_ACK     = 3'd5,
        ST_NAK     = 3'd6,
        ST_OTHER   = 3'd7
    } t_status;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_beat;

    typedef struct packed {
        logic        opt_step;
        logic        long_enough;
        logic        xid_ok;
        logic        cookie_ok;
        logic [31:0] client;
        logic [31:0] server;
    } t_hdr_stat;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] good;
        logic [7:0]           type_code;
        logic [3:0][31:0]     cand;
    } t_opt_stat;

    function automatic logic [NUM_SLOTS-1:0] slot_mask(input logic [7:0] code);
        logic [NUM_SLOTS-1:0] m;
        m = '0;
        case (code)
            OPT_TYPE:   m = 5'b00001;
            OPT_SERVER: m = 5'b00010;
            OPT_MASK:   m = 5'b00100;
            OPT_ROUTER: m = 5'b01000;
            OPT_DNS:    m = 5'b10000;
            default:    m = '0;
        endcase
        return m;
    endfunction

endpackage

>>> rtl/core/dhcprp_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcprp_in_reg
// Input register: holds one byte beat until the parse stage takes it.
// ----------------------------------------------------------------------------
module dhcprp_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dhcprp_pkg::t_beat   i_beat,
    input  logic                i_take,
    output logic                o_valid,
    output dhcprp_pkg::t_beat   o_beat
);
    import dhcprp_pkg::*;

    logic  r_valid;
    t_beat r_beat;

    assign o_in_ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_beat     = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_beat <= i_beat;
        end
    end

endmodule

>>> rtl/core/dhcprp_hdr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcprp_hdr
// Byte counter and fixed-header checks (xid, yiaddr, siaddr, cookie).
// ----------------------------------------------------------------------------
module dhcprp_hdr (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_clr,
    input  logic [7:0]            i_byte,
    input  logic [31:0]           i_exp_xid,
    output dhcprp_pkg::t_hdr_stat o_stat
);
    import dhcprp_pkg::*;

    logic [15:0] r_pos, n_pos;
    logic [31:0] r_shift, n_shift;
    logic        r_xid_ok, n_xid_ok;
    logic        r_cookie_ok, n_cookie_ok;
    logic [31:0] r_client, n_client;
    logic [31:0] r_server, n_server;
    logic        step;
    logic        hdr_step;

    assign step     = i_en && (r_pos != POS_MAX);
    assign hdr_step = step && (r_pos < HDR_LEN);

    always_comb begin
        n_pos       = step ? r_pos + 16'd1 : r_pos;
        n_shift     = r_shift;
        n_xid_ok    = r_xid_ok;
        n_cookie_ok = r_cookie_ok;
        n_client    = r_client;
        n_server    = r_server;
        if (hdr_step) begin
            n_shift = {r_shift[23:0], i_byte};
            if (r_pos == XID_LAST && n_shift != i_exp_xid) begin
                n_xid_ok = 1'b0;
            end
            if (r_pos == YIADDR_LAST) begin
                n_client = n_shift;
            end
            if (r_pos == SIADDR_LAST) begin
                n_server = n_shift;
            end
            if (r_pos == COOKIE_LAST && n_shift != DHCP_COOKIE) begin
                n_cookie_ok = 1'b0;
            end
        end
    end

    assign o_stat.opt_step    = step && (r_pos >= HDR_LEN);
    assign o_stat.long_enough = (n_pos >= HDR_LEN);
    assign o_stat.xid_ok      = n_xid_ok;
    assign o_stat.cookie_ok   = n_cookie_ok;
    assign o_stat.client      = n_client;
    assign o_stat.server      = n_server;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_pos       <= '0;
            r_shift     <= '0;
            r_xid_ok    <= 1'b1;
            r_cookie_ok <= 1'b1;
            r_client    <= '0;
            r_server    <= '0;
        end else begin
            r_pos       <= n_pos;
            r_shift     <= n_shift;
            r_xid_ok    <= n_xid_ok;
            r_cookie_ok <= n_cookie_ok;
            r_client    <= n_client;
            r_server    <= n_server;
        end
    end

endmodule

>>> rtl/core/dhcprp_opt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcprp_opt
// Option list walker: tracks code/length/data and latches first options.
// ----------------------------------------------------------------------------
module dhcprp_opt (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_clr,
    input  logic [7:0]            i_byte,
    output dhcprp_pkg::t_opt_stat o_stat
);
    import dhcprp_pkg::*;

    typedef enum logic [3:0] {
        PH_CODE = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_DATA = 4'b0100,
        PH_STOP = 4'b1000
    } t_phase;

    t_phase               r_phase, n_phase;
    logic [7:0]           r_code, n_code;
    logic [7:0]           r_left, n_left;
    logic [2:0]           r_seen, n_seen;
    logic [31:0]          r_shift, n_shift;
    logic [NUM_SLOTS-1:0] r_started, n_started;
    logic [NUM_SLOTS-1:0] r_complete, n_complete;
    logic [NUM_SLOTS-1:0] r_lenok, n_lenok;
    logic [7:0]           r_mtype, n_mtype;
    logic [3:0][31:0]     r_cand, n_cand;

    always_comb begin
        logic [NUM_SLOTS-1:0] m;
        logic [NUM_SLOTS-1:0] hit;
        logic [NUM_SLOTS-1:0] fm;
        logic                 len_ok;
        logic                 do_fin;
        m          = slot_mask(r_code);
        hit        = m & ~r_complete;
        fm         = '0;
        len_ok     = 1'b0;
        do_fin     = 1'b0;
        n_phase    = r_phase;
        n_code     = r_code;
        n_left     = r_left;
        n_seen     = r_seen;
        n_shift    = r_shift;
        n_started  = r_started;
        n_complete = r_complete;
        n_lenok    = r_lenok;
        n_mtype    = r_mtype;
        n_cand     = r_cand;
        if (i_en) begin
            case (r_phase)
                PH_CODE: begin
                    if (i_byte == OPT_END) begin
                        n_phase = PH_STOP;
                    end else if (i_byte != OPT_PAD) begin
                        n_code  = i_byte;
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_left    = i_byte;
                    n_seen    = '0;
                    n_shift   = '0;
                    n_started = r_started | hit;
                    len_ok    = (m[0] && i_byte != 8'd0)
                             || ((m[1] || m[2]) && i_byte == 8'd4)
                             || ((m[3] || m[4]) && i_byte >= 8'd4);
                    n_lenok   = len_ok ? (r_lenok | hit) : (r_lenok & ~hit);
                    if (i_byte == 8'd0) begin
                        do_fin = 1'b1;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (m[0] && r_seen == 3'd0 && r_started[0]) begin
                        n_mtype = i_byte;
                    end
                    if (r_seen < 3'd4) begin
                        n_shift = {r_shift[23:0], i_byte};
                        n_seen  = r_seen + 3'd1;
                    end
                    n_left = r_left - 8'd1;
                    if (n_left == 8'd0) begin
                        do_fin = 1'b1;
                    end
                end
                PH_STOP: begin
                end
                default: begin
                end
            endcase
        end
        // option done: first complete occurrence latches its value
        if (do_fin) begin
            fm         = m & n_started;
            n_started  = n_started & ~fm;
            n_complete = n_complete | fm;
            for (int i = 0; i < 4; i++) begin
                if (fm[i+1]) begin
                    n_cand[i] = n_shift;
                end
            end
            n_phase = PH_CODE;
        end
    end

    assign o_stat.good      = n_complete & n_lenok;
    assign o_stat.type_code = n_mtype;
    assign o_stat.cand      = n_cand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_phase    <= PH_CODE;
            r_code     <= '0;
            r_left     <= '0;
            r_seen     <= '0;
            r_shift    <= '0;
            r_started  <= '0;
            r_complete <= '0;
            r_lenok    <= '0;
            r_mtype    <= '0;
            r_cand     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_code     <= n_code;
            r_left     <= n_left;
            r_seen     <= n_seen;
            r_shift    <= n_shift;
            r_started  <= n_started;
            r_complete <= n_complete;
            r_lenok    <= n_lenok;
            r_mtype    <= n_mtype;
            r_cand     <= n_cand;
        end
    end

endmodule

>>> rtl/core/dhcp_reply_parser.sv
`timescale 1ns / 1ps
// A packet's result is registered once its last byte beat leaves the input register.
// Throughput: one byte beat per cycle; one input register and one parse stage.
// A held result stalls the input only when the next parsed beat ends a packet.
// Reset (synchronous, active low) clears all parse state, expected_xid to 0,
// the lease fields to 0 and the netmask to 0xFFFFFF00.
// ----------------------------------------------------------------------------
// dhcp_reply_parser
// Parses a DHCP reply payload byte by byte and reports the reply type,
// updating the stored lease fields when an OFFER is seen.
// ----------------------------------------------------------------------------
module dhcp_reply_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: expected transaction id
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    // byte input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [31:0] o_offered_address,
    output logic [31:0] o_server_address,
    output logic [31:0] o_subnet_mask,
    output logic [31:0] o_gateway_address,
    output logic [31:0] o_dns_address
);
    import dhcprp_pkg::*;

    logic [31:0] r_exp_xid;

    // input register stage
    t_beat in_beat;
    t_beat q_beat;
    logic  q_valid;
    logic  proc_fire;
    logic  res_load;

    assign in_beat.data = i_data_byte;
    assign in_beat.last = i_last_byte;

    dhcprp_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_beat     (in_beat),
        .i_take     (proc_fire),
        .o_valid    (q_valid),
        .o_beat     (q_beat)
    );

    // The held beat is parsed unless it ends a packet and the result
    // register is still occupied.
    logic r_out_valid;
    assign proc_fire = q_valid && (!q_beat.last || !r_out_valid || i_out_ready);
    assign res_load  = proc_fire && q_beat.last;

    // parse stage: header unit and option walker, both cleared at packet end
    t_hdr_stat hdr;
    t_opt_stat opt;

    dhcprp_hdr u_hdr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (proc_fire),
        .i_clr     (res_load),
        .i_byte    (q_beat.data),
        .i_exp_xid (r_exp_xid),
        .o_stat    (hdr)
    );

    dhcprp_opt u_opt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (hdr.opt_step),
        .i_clr   (res_load),
        .i_byte  (q_beat.data),
        .o_stat  (opt)
    );

    // Status is decided from the state as it stands after this beat.
    t_status n_status;
    always_comb begin
        if (!hdr.long_enough) begin
            n_status = ST_SHORT;
        end else if (!hdr.xid_ok) begin
            n_status = ST_XID;
        end else if (!hdr.cookie_ok) begin
            n_status = ST_COOKIE;
        end else if (!opt.good[0]) begin
            n_status = ST_NO_TYPE;
        end else begin
            case (opt.type_code)
                MT_OFFER: n_status = ST_OFFER;
                MT_ACK:   n_status = ST_ACK;
                MT_NAK:   n_status = ST_NAK;
                default:  n_status = ST_OTHER;
            endcase
        end
    end

    // Result register. The lease registers double as the output payload:
    // they only move when a new result is loaded.
    t_status     r_status;
    logic [31:0] r_lease_address;
    logic [31:0] r_lease_server;
    logic [31:0] r_lease_mask;
    logic [31:0] r_lease_gateway;
    logic [31:0] r_lease_dns;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_xid <= '0;
        end else if (i_cfg_we) begin
            r_exp_xid <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lease_address <= '0;
            r_lease_server  <= '0;
            r_lease_mask    <= MASK_RESET;
            r_lease_gateway <= '0;
            r_lease_dns     <= '0;
        end else if (res_load && n_status == ST_OFFER) begin
            r_lease_address <= hdr.client;
            // server id option wins over siaddr when it is exactly 4 bytes
            r_lease_server  <= opt.good[1] ? opt.cand[0] : hdr.server;
            if (opt.good[2]) begin
                r_lease_mask <= opt.cand[1];
            end
            if (opt.good[3]) begin
                r_lease_gateway <= opt.cand[2];
            end
            if (opt.good[4]) begin
                r_lease_dns <= opt.cand[3];
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_offered_address = r_lease_address;
    assign o_server_address  = r_lease_server;
    assign o_subnet_mask     = r_lease_mask;
    assign o_gateway_address = r_lease_gateway;
    assign o_dns_address     = r_lease_dns;

`ifndef NO_ASSERTIONS
    // a loaded result is presented on the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |=> r_out_valid)
        else $error("result load did not raise valid");

    // a new result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten while held");

    // a beat that is not parsed stays in the input register
    a_beat_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && !proc_fire) |=> (q_valid && $stable(q_beat)))
        else $error("input beat lost");

    // lease fields move only together with an OFFER result
    a_lease_offer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_lease_address))
            |-> (r_out_valid && r_status == ST_OFFER))
        else $error("lease changed without offer");
`endif

endmodule

>>> bench/dhcp_reply_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_reply_parser_tb
// Self-checking bench for the DHCP reply parser. Byte beats are pushed
// through the valid/ready input with random gaps, results are pulled with
// random back-pressure, and every result is compared field by field with a
// bit-accurate parse model kept inside the bench. Directed replies cover
// header rejects, every reply type, option length rules, first-occurrence
// handling, truncation and xid changes; randomized replies follow.
// ----------------------------------------------------------------------------
module dhcp_reply_parser_tb;
    import dhcprp_pkg::*;

    localparam int CYCLE_LIMIT        = 4_000_000;
    localparam int SETTLE_CYCLES      = 8;     // margin for the pipe to empty
    localparam int NO_SLOT            = 5;
    localparam int RANDOM_MIN_BYTES   = 1000;
    localparam int RANDOM_MIN_REPLIES = 4;

    // option walk phases of the parse model
    typedef enum logic [1:0] {
        WALK_CODE,
        WALK_LEN,
        WALK_DATA,
        WALK_STOP
    } t_walk;

    typedef struct {
        t_status     status;
        logic [31:0] offered;
        logic [31:0] server;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [31:0] dns;
    } t_lease_report;

    // ------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_status;
    logic [31:0] o_offered_address;
    logic [31:0] o_server_address;
    logic [31:0] o_subnet_mask;
    logic [31:0] o_gateway_address;
    logic [31:0] o_dns_address;

    dhcp_reply_parser u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_data_byte       (i_data_byte),
        .i_last_byte       (i_last_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_offered_address (o_offered_address),
        .o_server_address  (o_server_address),
        .o_subnet_mask     (o_subnet_mask),
        .o_gateway_address (o_gateway_address),
        .o_dns_address     (o_dns_address)
    );

    // ------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------
    t_lease_report pending_reports[$];   // expected results, oldest first
    logic [7:0]    reply_bytes[$];       // reply under construction
    int            fail_count;
    int            cycle_count;
    int            bytes_sent;
    int            replies_predicted;
    logic          steady_flow;          // no gaps, no back-pressure

    logic [7:0] value_codes[4] = '{OPT_SERVER, OPT_MASK, OPT_ROUTER, OPT_DNS};

    // ------------------------------------------------------------------
    // Parse model state: one copy of the per-reply state plus the lease
    // ------------------------------------------------------------------
    logic [31:0]   xid_setting;
    logic [15:0]   parse_pos;
    t_walk         walk;
    logic [7:0]    opt_code;
    logic [7:0]    opt_left;
    logic [7:0]    opt_seen;
    logic [31:0]   shifter;
    logic          xid_ok;
    logic          cookie_ok;
    logic [31:0]   yiaddr_hdr;
    logic [31:0]   siaddr_hdr;
    // slot bits: 0 type, 1 server id, 2 mask, 3 router, 4 dns
    logic [4:0]    opt_open;
    logic [4:0]    opt_done;
    logic [4:0]    opt_len_ok;
    logic [7:0]    type_value;
    logic [31:0]   opt_value[4];         // server id, mask, router, dns
    t_lease_report lease_now;            // status field unused here

    function automatic int slot_of(logic [7:0] code);
        case (code)
            OPT_TYPE:   return 0;
            OPT_SERVER: return 1;
            OPT_MASK:   return 2;
            OPT_ROUTER: return 3;
            OPT_DNS:    return 4;
            default:    return NO_SLOT;
        endcase
    endfunction

    function automatic void clear_parse_state();
        parse_pos  = '0;
        walk       = WALK_CODE;
        opt_code   = '0;
        opt_left   = '0;
        opt_seen   = '0;
        shifter    = '0;
        xid_ok     = 1'b1;
        cookie_ok  = 1'b1;
        yiaddr_hdr = '0;
        siaddr_hdr = '0;
        opt_open   = '0;
        opt_done   = '0;
        opt_len_ok = '0;
        type_value = '0;
        foreach (opt_value[k]) opt_value[k] = '0;
    endfunction

    // an option ends: first occurrence becomes complete, value latched
    function automatic void close_option();
        int s;
        s = slot_of(opt_code);
        if (s != NO_SLOT && opt_open[s]) begin
            opt_open[s] = 1'b0;
            opt_done[s] = 1'b1;
            if (s > 0) opt_value[s-1] = shifter;
        end
        walk = WALK_CODE;
    endfunction

    function automatic void take_header_byte(logic [15:0] idx, logic [7:0] b);
        shifter = {shifter[23:0], b};
        if (idx == XID_LAST && shifter != xid_setting) xid_ok = 1'b0;
        if (idx == YIADDR_LAST) yiaddr_hdr = shifter;
        if (idx == SIADDR_LAST) siaddr_hdr = shifter;
        if (idx == COOKIE_LAST) begin
            if (shifter != DHCP_COOKIE) cookie_ok = 1'b0;
            shifter = '0;
        end
    endfunction

    function automatic void take_option_byte(logic [7:0] b);
        int   s;
        logic ok;
        s = slot_of(opt_code);
        case (walk)
            WALK_CODE: begin
                if (b == OPT_END) begin
                    walk = WALK_STOP;
                end else if (b != OPT_PAD) begin
                    opt_code = b;
                    walk     = WALK_LEN;
                end
            end
            WALK_LEN: begin
                opt_left = b;
                opt_seen = '0;
                shifter  = '0;
                if (s != NO_SLOT && !opt_done[s]) begin
                    opt_open[s] = 1'b1;
                    if (s == 0) ok = (b >= 8'd1);
                    else if (s <= 2) ok = (b == 8'd4);
                    else ok = (b >= 8'd4);
                    opt_len_ok[s] = ok;
                end
                if (b == 8'd0) close_option();
                else walk = WALK_DATA;
            end
            WALK_DATA: begin
                if (s == 0 && opt_seen == 8'd0 && opt_open[0]) type_value = b;
                if (opt_seen < 8'd4) begin
                    shifter  = {shifter[23:0], b};
                    opt_seen = opt_seen + 8'd1;
                end
                opt_left = opt_left - 8'd1;
                if (opt_left == 8'd0) close_option();
            end
            default: ;
        endcase
    endfunction

    // one accepted beat; a marked beat queues the expected result
    function automatic void predict_byte(logic [7:0] b, logic last);
        t_lease_report rpt;
        logic [15:0]   idx;
        logic [4:0]    good;
        t_status       st;
        if (parse_pos < POS_MAX) begin
            idx       = parse_pos;
            parse_pos = parse_pos + 16'd1;
            if (idx < HDR_LEN) take_header_byte(idx, b);
            else take_option_byte(b);
        end
        if (last) begin
            good = opt_done & opt_len_ok;
            if (parse_pos < HDR_LEN) st = ST_SHORT;
            else if (!xid_ok) st = ST_XID;
            else if (!cookie_ok) st = ST_COOKIE;
            else if (!opt_done[0] || !opt_len_ok[0]) st = ST_NO_TYPE;
            else if (type_value == MT_OFFER) begin
                st                = ST_OFFER;
                lease_now.offered = yiaddr_hdr;
                lease_now.server  = good[1] ? opt_value[0] : siaddr_hdr;
                if (good[2]) lease_now.mask    = opt_value[1];
                if (good[3]) lease_now.gateway = opt_value[2];
                if (good[4]) lease_now.dns     = opt_value[3];
            end
            else if (type_value == MT_ACK) st = ST_ACK;
            else if (type_value == MT_NAK) st = ST_NAK;
            else st = ST_OTHER;
            rpt        = lease_now;
            rpt.status = st;
            pending_reports.push_back(rpt);
            replies_predicted++;
            clear_parse_state();
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial cycle_count = 0;
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure, changed on the falling edge
    // ------------------------------------------------------------------
    initial begin
        int hold;
        int stall;
        hold        = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (steady_flow) begin
                i_out_ready <= 1'b1;
                hold = 0;
            end else if (hold > 0) begin
                hold--;
            end else if (i_out_ready) begin
                stall = pick_gap();
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    hold = stall - 1;
                end else begin
                    hold = $urandom_range(0, 15);
                end
            end else begin
                i_out_ready <= 1'b1;
                hold = $urandom_range(0, 15);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted result against the oldest expectation
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    initial begin
        t_lease_report want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (pending_reports.size() == 0) begin
                    $display("%0t: result with none expected, status %h", $time, o_status);
                    fail_count++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("status",  32'(want.status), 32'(o_status));
                    check_field("offered", want.offered,     o_offered_address);
                    check_field("server",  want.server,      o_server_address);
                    check_field("mask",    want.mask,        o_subnet_mask);
                    check_field("gateway", want.gateway,     o_gateway_address);
                    check_field("dns",     want.dns,         o_dns_address);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Byte side. Every task starts and ends on a falling edge; valid stays
    // high between back-to-back beats and is dropped only by a gap or a
    // drain, so it gets one assignment per time step.
    // ------------------------------------------------------------------
    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_byte(b, last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_reply();
        foreach (reply_bytes[i]) send_byte(reply_bytes[i], i == reply_bytes.size() - 1);
    endtask

    // hold off the sender until every result is in, then let the pipe empty
    task automatic wait_for_reports();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_xid(logic [31:0] x);
        wait_for_reports();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= x;
        xid_setting = x;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Reply builders
    // ------------------------------------------------------------------
    task automatic push_word(logic [31:0] w);
        for (int k = 3; k >= 0; k--) reply_bytes.push_back(w[8*k +: 8]);
    endtask

    task automatic push_random(int n);
        repeat (n) reply_bytes.push_back(8'($urandom));
    endtask

    // 240-byte fixed header; fields not looked at are random
    task automatic start_reply(logic [31:0] xid, logic [31:0] yiaddr,
                               logic [31:0] siaddr, logic [31:0] cookie);
        reply_bytes.delete();
        push_random(4);
        push_word(xid);
        push_random(8);
        push_word(yiaddr);
        push_word(siaddr);
        push_random(212);
        push_word(cookie);
    endtask

    // value bytes come from val big-endian, beyond four bytes random
    task automatic add_option(logic [7:0] code, logic [7:0] len, logic [31:0] val);
        reply_bytes.push_back(code);
        reply_bytes.push_back(len);
        for (int k = 0; k < len; k++)
            reply_bytes.push_back(k < 4 ? val[31-8*k -: 8] : 8'($urandom));
    endtask

    function automatic logic [7:0] pick_type();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return MT_OFFER;
        if (r < 65) return MT_ACK;
        if (r < 80) return MT_NAK;
        return 8'($urandom);
    endfunction

    task automatic add_full_lease();
        add_option(OPT_SERVER, 8'd4, $urandom);
        add_option(OPT_MASK,   8'd4, $urandom);
        add_option(OPT_ROUTER, 8'd4, $urandom);
        add_option(OPT_DNS,    8'd4, $urandom);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_short_replies();
        // one-beat reply, then one byte short of a header: lease at reset
        reply_bytes.delete();
        push_random(1);
        send_reply();
        reply_bytes.delete();
        push_random(239);
        send_reply();
        // exactly a header, nothing after it
        start_reply(xid_setting, $urandom, $urandom, DHCP_COOKIE);
        send_reply();
    endtask

    task automatic test_header_checks();
        start_reply(~xid_setting, $urandom, $urandom, DHCP_COOKIE);
        add_option(OPT_TYPE, 8'd1, {MT_OFFER, 24'h0});
        add_full_lease();
        send_reply();
        start_reply(xid_setting, $urandom, $urandom, DHCP_COOKIE ^ 32'h1);
        add_option(OPT_TYPE, 8'd1, {MT_OFFER, 24'h0});
        send_reply();
        // both wrong: xid takes priority
        start_reply(~xid_setting, $urandom, $urandom, ~DHCP_COOKIE);
        send_reply();
    endtask

    task automatic test_message_types();
        logic [7:0] kinds[6] = '{MT_OFFER, MT_ACK, MT_NAK, 8'd1, 8'd0, 8'hFF};
        foreach (kinds[k]) begin
            start_reply(xid_setting, $urandom, $urandom, DHCP_COOKIE);
            add_option(OPT_TYPE, 8'd1, {kinds[k], 24'h0});
            add_full_lease();
            reply_bytes.push_back(OPT_END);
            send_reply();
        end
        // longer type option: first value byte counts
        start_reply(xid_setting, $urandom, $urandom, DHCP_COOKIE);
        add_option(OPT_TYPE, 8'd3, {MT_ACK, 24'($urandom)});
        send_reply();
        // empty type option is the first complete one, so a later one is ignored
        start_reply(xid_setting, $urandom, $urandom, DHCP_COOKIE);
        add_option(OPT_TYPE, 8'd0, 32'h0);
        add_option(OPT_TYPE, 8'd1, {MT_OFFER, 24'h0});
        send_reply();
    endtask

    task automatic test_offer_options();
        // server id and mask need exactly 4, router and dns at least 4
        start_reply(xid_setting, $urandom, $urandom, DHCP_COOKIE);
        add_option(OPT_TYPE,   8'd1, {MT_OFFER, 24'h0});
        add_option(OPT_SERVER, 8'd3, $urandom);
        add_option(OPT_MASK,   8'd5, $urandom);
        add_option(OPT_ROUTER, 8'd8, $urandom);
        add_option(OPT_DNS,    8'd3, $urandom);
        send_reply();
        // repeats are ignored, even after a badly sized first one;
        // pads and unknown codes skipped; nothing counts after the end code
        start_reply(xid_setting, $urandom, $urandom, DHCP_COOKIE);
        add_option(OPT_MASK, 8'd2, $urandom);
        add_option(OPT_MASK, 8'd4, $urandom);
        repeat (3) reply_bytes.push_back(OPT_PAD);
        add_option(8'd200, 8'd0, 32'h0);
        add_option(8'd77, 8'd255, $urandom);
        add_option(OPT_TYPE,   8'd1, {MT_OFFER, 24'h0});
        add_option(OPT_SERVER, 8'd4, $urandom);
        add_option(OPT_SERVER, 8'd4, $urandom);
        add_option(OPT_ROUTER, 8'd4, $urandom);
        reply_bytes.push_back(OPT_END);
        add_option(OPT_DNS, 8'd4, $urandom);
        send_reply();
        // reply ends inside the server id option: falls back to siaddr
        start_reply(xid_setting, $urandom, $urandom, DHCP_COOKIE);
        add_option(OPT_TYPE,   8'd1, {MT_OFFER, 24'h0});
        add_option(OPT_DNS,    8'd4, $urandom);
        add_option(OPT_SERVER, 8'd4, $urandom);
        void'(reply_bytes.pop_back());
        void'(reply_bytes.pop_back());
        send_reply();
        // an ACK leaves the lease alone
        start_reply(xid_setting, $urandom, $urandom, DHCP_COOKIE);
        add_option(OPT_TYPE, 8'd1, {MT_ACK, 24'h0});
        add_full_lease();
        send_reply();
    endtask

    task automatic test_xid_register();
        write_xid(32'hFFFF_FFFF);
        start_reply(32'hFFFF_FFFF, $urandom, $urandom, DHCP_COOKIE);
        add_option(OPT_TYPE, 8'd1, {MT_ACK, 24'h0});
        send_reply();
        start_reply(32'h0, $urandom, $urandom, DHCP_COOKIE);
        send_reply();
        write_xid(32'h0);
        start_reply(32'h0, $urandom, $urandom, DHCP_COOKIE);
        add_option(OPT_TYPE, 8'd1, {MT_OFFER, 24'h0});
        add_full_lease();
        send_reply();
        write_xid($urandom);
        start_reply(xid_setting, $urandom, $urandom, DHCP_COOKIE);
        add_option(OPT_TYPE, 8'd1, {MT_NAK, 24'h0});
        send_reply();
        // register rewritten after byte 3: the compare at byte 7 sees the new id
        write_xid(32'hFFFF_FFFF);
        start_reply(32'h5A5A_A5A5, $urandom, $urandom, DHCP_COOKIE);
        add_option(OPT_TYPE, 8'd1, {MT_ACK, 24'h0});
        foreach (reply_bytes[i]) begin
            send_byte(reply_bytes[i], i == reply_bytes.size() - 1);
            if (i == 3) write_xid(32'h5A5A_A5A5);
        end
    endtask

    // one random reply into reply_bytes: mostly well formed with random
    // options, some short, some with a bad xid or cookie, some noise
    task automatic random_reply();
        int          kind;
        int          n;
        int          r;
        logic [7:0]  len;
        logic [31:0] xid;
        logic [31:0] cookie;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            reply_bytes.delete();
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 239) : $urandom_range(1, 24);
            push_random(n);
            return;
        end
        xid    = xid_setting;
        cookie = DHCP_COOKIE;
        if (kind < 22) xid = xid ^ (32'd1 << $urandom_range(0, 31));
        else if (kind < 30) cookie = cookie ^ (32'd1 << $urandom_range(0, 31));
        start_reply(xid, $urandom, $urandom, cookie);
        if (kind >= 92) begin
            push_random($urandom_range(0, 48));
            return;
        end
        if ($urandom_range(0, 9) < 7) add_option(OPT_TYPE, 8'd1, {pick_type(), 24'($urandom)});
        n = $urandom_range(0, 8);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                len = ($urandom_range(0, 4) != 0) ? 8'd1 : 8'($urandom_range(0, 3));
                add_option(OPT_TYPE, len, {pick_type(), 24'($urandom)});
            end else if (r < 65) begin
                len = ($urandom_range(0, 3) != 0) ? 8'd4 : 8'($urandom_range(0, 8));
                add_option(value_codes[$urandom_range(0, 3)], len, $urandom);
            end else if (r < 77) begin
                repeat ($urandom_range(1, 3)) reply_bytes.push_back(OPT_PAD);
            end else if (r < 92) begin
                add_option(8'($urandom), 8'($urandom_range(0, 10)), $urandom);
            end else begin
                reply_bytes.push_back(OPT_END);
                push_random($urandom_range(0, 6));
            end
        end
        // cut the tail now and then so the last option is truncated
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 5))
                if (reply_bytes.size() > 241) void'(reply_bytes.pop_back());
        end
    endtask

    task automatic test_random_replies();
        int start_bytes;
        int start_replies;
        int count;
        start_bytes   = bytes_sent;
        start_replies = replies_predicted;
        count         = 0;
        while (bytes_sent - start_bytes < RANDOM_MIN_BYTES ||
               replies_predicted - start_replies < RANDOM_MIN_REPLIES) begin
            if (count % 10 == 9) begin
                case ($urandom_range(0, 3))
                    0:       write_xid(32'h0);
                    1:       write_xid(32'hFFFF_FFFF);
                    default: write_xid($urandom);
                endcase
            end
            steady_flow = (count % 8 == 5);
            random_reply();
            send_reply();
            count++;
        end
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        fail_count        = 0;
        bytes_sent        = 0;
        replies_predicted = 0;
        steady_flow       = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        i_in_valid        = 1'b0;
        i_data_byte       = '0;
        i_last_byte       = 1'b0;

        // model reset matches the block's reset
        xid_setting       = '0;
        clear_parse_state();
        lease_now.status  = ST_SHORT;
        lease_now.offered = '0;
        lease_now.server  = '0;
        lease_now.mask    = MASK_RESET;
        lease_now.gateway = '0;
        lease_now.dns     = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_short_replies();
        wait_for_reports();
        test_header_checks();
        wait_for_reports();
        test_message_types();
        wait_for_reports();
        test_offer_options();
        test_xid_register();
        wait_for_reports();
        test_random_replies();
        wait_for_reports();

        if (fail_count == 0 && pending_reports.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
